@@ hw/rtl/svdpp_pkg.sv @@
// ----------------------------------------------------------------------------
// svdpp_pkg
// Shared types, field widths, opcodes, the microcode program and the
// reciprocal square root table function of the SVD++ rating predictor.
// ----------------------------------------------------------------------------
package svdpp_pkg;

    // Field and datapath widths
    localparam int LANES     = 5;
    localparam int FACT_W    = 16;                  // Q3.12 factor element
    localparam int SUM_W     = 25;                  // neighbour sum lane
    localparam int CNT_W     = 9;                   // neighbour count
    localparam int RSQ_W     = 17;                  // unsigned Q1.16
    localparam int ROM_DEPTH = 1 << CNT_W;
    localparam int LANE_W    = 3;
    localparam int MUL_A_W   = 27;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 48;
    localparam int RATING_W  = 32;

    // Opcodes of an input request
    localparam logic [1:0] OP_NEIGHBOUR = 2'd0;
    localparam logic [1:0] OP_USER      = 2'd1;
    localparam logic [1:0] OP_MOVIE     = 2'd2;

    localparam logic signed [RATING_W-1:0] RATING_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATING_W-1:0] RATING_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [FACT_W-1:0] f0;
        logic signed [FACT_W-1:0] f1;
        logic signed [FACT_W-1:0] f2;
        logic signed [FACT_W-1:0] f3;
        logic signed [FACT_W-1:0] f4;
    } in_t;

    typedef struct packed {
        logic signed [RATING_W-1:0] rating;
        logic [CNT_W-1:0]           neighbours_used;
        logic                       saturated;
    } out_t;

    // Microcode
    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE   = 3'd0;
    localparam step_t ST_SETUP  = 3'd1;
    localparam step_t ST_MUL_SR = 3'd2;
    localparam step_t ST_ADD_U  = 3'd3;
    localparam step_t ST_MUL_UQ = 3'd4;
    localparam step_t ST_ACC    = 3'd5;
    localparam step_t ST_EMIT   = 3'd6;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SUM_R,
        MUL_U_Q
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        LANE_HOLD,
        LANE_CLEAR,
        LANE_INC
    } lane_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF_START,
        JMP_IF_MORE,
        JMP_IF_FREE
    } jump_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     load_u;
        acc_op_t  acc_op;
        lane_op_t lane_op;
        logic     emit;
        logic     take_input;
        jump_t    jump;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic lane_more;
        logic out_free;
    } stat_t;

    function automatic ctrl_t ucode(input step_t addr);
        ctrl_t w;
        w = '{mul_sel: MUL_NONE, load_u: 1'b0, acc_op: ACC_HOLD, lane_op: LANE_HOLD,
              emit: 1'b0, take_input: 1'b0, jump: JMP_NEXT, target: ST_IDLE};
        unique case (addr)
            ST_IDLE: begin
                w.take_input = 1'b1;
                w.jump       = JMP_IF_START;
                w.target     = ST_SETUP;
            end
            ST_SETUP: begin
                w.acc_op  = ACC_CLEAR;
                w.lane_op = LANE_CLEAR;
            end
            ST_MUL_SR: begin
                w.mul_sel = MUL_SUM_R;
            end
            ST_ADD_U: begin
                w.load_u = 1'b1;
            end
            ST_MUL_UQ: begin
                w.mul_sel = MUL_U_Q;
            end
            ST_ACC: begin
                w.acc_op  = ACC_ADD;
                w.lane_op = LANE_INC;
                w.jump    = JMP_IF_MORE;
                w.target  = ST_MUL_SR;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.jump   = JMP_IF_FREE;
                w.target = ST_IDLE;
            end
            default: begin
                w.jump   = JMP_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // round(65536 / sqrt(n)): largest r with (2r-1)^2 * n <= 2^34, zero for n = 0.
    // Evaluated at elaboration only.
    function automatic logic [RSQ_W-1:0] rsqrt_q16(input int n);
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] odd;
        r = 64'd0;
        if (n == 0) begin
            return '0;
        end
        for (int b = RSQ_W - 1; b >= 0; b--) begin
            t   = r | (64'd1 << b);
            odd = 2 * t - 64'd1;
            if (t <= (64'd1 << (RSQ_W - 1)) && odd * odd * 64'(n) <= (64'd1 << 34)) begin
                r = t;
            end
        end
        return r[RSQ_W-1:0];
    endfunction

endpackage

@@ hw/rtl/svdpp_rsqrt_rom.sv @@
// ----------------------------------------------------------------------------
// svdpp_rsqrt_rom
// Reciprocal square root table over the neighbour count, registered read.
// ----------------------------------------------------------------------------
module svdpp_rsqrt_rom (
    input  logic                          aclk,
    input  logic [svdpp_pkg::CNT_W-1:0]   count_i,
    output logic [svdpp_pkg::RSQ_W-1:0]   rsq_o
);

    logic [svdpp_pkg::RSQ_W-1:0] rom_w [svdpp_pkg::ROM_DEPTH];
    logic [svdpp_pkg::RSQ_W-1:0] rsq_reg;

    for (genvar g = 0; g < svdpp_pkg::ROM_DEPTH; g++) begin : g_rom
        localparam logic [svdpp_pkg::RSQ_W-1:0] VAL = svdpp_pkg::rsqrt_q16(g);
        assign rom_w[g] = VAL;
    end

    always_ff @(posedge aclk) begin
        rsq_reg <= rom_w[count_i];
    end

    assign rsq_o = rsq_reg;

endmodule

@@ hw/rtl/svdpp_seq.sv @@
// ----------------------------------------------------------------------------
// svdpp_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module svdpp_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  svdpp_pkg::stat_t        stat_i,
    output svdpp_pkg::ctrl_t        ctrl_o
);

    svdpp_pkg::step_t step_reg;
    svdpp_pkg::step_t step_next;
    svdpp_pkg::ctrl_t word;

    assign word = svdpp_pkg::ucode(step_reg);

    always_comb begin
        ctrl_o      = word;
        // hold the result step until the output register frees up
        ctrl_o.emit = word.emit & stat_i.out_free;
    end

    always_comb begin
        unique case (word.jump)
            svdpp_pkg::JMP_NEXT:     step_next = step_reg + 3'd1;
            svdpp_pkg::JMP_GOTO:     step_next = word.target;
            svdpp_pkg::JMP_IF_START: step_next = stat_i.start ? word.target : step_reg;
            svdpp_pkg::JMP_IF_MORE:  step_next = stat_i.lane_more ? word.target
                                                                  : step_reg + 3'd1;
            svdpp_pkg::JMP_IF_FREE:  step_next = stat_i.out_free ? word.target : step_reg;
            default:                 step_next = svdpp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= svdpp_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hw/rtl/svdpp_dp.sv @@
// ----------------------------------------------------------------------------
// svdpp_dp
// Lane registers, shared multiplier, rounding, accumulator and saturation.
// ----------------------------------------------------------------------------
module svdpp_dp #(
    parameter int FACTORS        = 5,
    parameter int MAX_NEIGHBOURS = 300
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  svdpp_pkg::ctrl_t                      ctrl_i,
    input  logic                                  in_fire_i,
    input  svdpp_pkg::in_t                        in_data_i,
    input  logic [svdpp_pkg::RSQ_W-1:0]           rsq_i,
    output logic                                  lane_more_o,
    output logic [svdpp_pkg::CNT_W-1:0]           count_o,
    output logic signed [svdpp_pkg::RATING_W-1:0] rating_o,
    output logic                                  sat_o
);

    localparam int FW = svdpp_pkg::FACT_W;
    localparam int SW = svdpp_pkg::SUM_W;
    localparam int AW = svdpp_pkg::MUL_A_W;
    localparam int BW = svdpp_pkg::MUL_B_W;
    localparam int PW = svdpp_pkg::PROD_W;
    localparam int CW = svdpp_pkg::ACC_W;

    logic signed [FW-1:0] f_in [svdpp_pkg::LANES];

    logic signed [SW-1:0] sum_reg  [svdpp_pkg::LANES];
    logic signed [FW-1:0] user_reg [svdpp_pkg::LANES];
    logic signed [FW-1:0] q_reg    [svdpp_pkg::LANES];
    logic [svdpp_pkg::CNT_W-1:0]  count_reg;
    logic [svdpp_pkg::LANE_W-1:0] lane_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] u_reg;
    logic signed [CW-1:0] acc_reg;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_rnd;
    logic signed [PW-1:0] prod_sh;
    logic signed [AW-1:0] u_next;
    logic signed [CW-1:0] acc_rnd;
    logic signed [CW-1:0] acc_sh;
    logic [CW-1:svdpp_pkg::RATING_W-1] acc_hi;
    logic                 neighbour_ok;

    assign f_in[0] = in_data_i.f0;
    assign f_in[1] = in_data_i.f1;
    assign f_in[2] = in_data_i.f2;
    assign f_in[3] = in_data_i.f3;
    assign f_in[4] = in_data_i.f4;

    assign neighbour_ok = count_reg < svdpp_pkg::CNT_W'(MAX_NEIGHBOURS);

    // Lane state: neighbour sums, count and user factors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < svdpp_pkg::LANES; i++) begin
                sum_reg[i]  <= '0;
                user_reg[i] <= '0;
            end
            count_reg <= '0;
        end else if (ctrl_i.emit) begin
            for (int i = 0; i < svdpp_pkg::LANES; i++) begin
                sum_reg[i] <= '0;
            end
            count_reg <= '0;
        end else if (in_fire_i) begin
            if (in_data_i.op == svdpp_pkg::OP_NEIGHBOUR && neighbour_ok) begin
                for (int i = 0; i < FACTORS; i++) begin
                    sum_reg[i] <= sum_reg[i] + {{(SW-FW){f_in[i][FW-1]}}, f_in[i]};
                end
                count_reg <= count_reg + 9'd1;
            end else if (in_data_i.op == svdpp_pkg::OP_USER) begin
                for (int i = 0; i < FACTORS; i++) begin
                    user_reg[i] <= f_in[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire_i && in_data_i.op == svdpp_pkg::OP_MOVIE) begin
            for (int i = 0; i < svdpp_pkg::LANES; i++) begin
                q_reg[i] <= f_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
        end else begin
            unique case (ctrl_i.lane_op)
                svdpp_pkg::LANE_CLEAR: lane_reg <= '0;
                svdpp_pkg::LANE_INC:   lane_reg <= lane_reg + 3'd1;
                default:               lane_reg <= lane_reg;
            endcase
        end
    end

    assign lane_more_o = lane_reg != svdpp_pkg::LANE_W'(FACTORS - 1);

    // Shared multiplier: sum * R, then u * q
    always_comb begin
        unique case (ctrl_i.mul_sel)
            svdpp_pkg::MUL_SUM_R: begin
                mul_a = {{(AW-SW){sum_reg[lane_reg][SW-1]}}, sum_reg[lane_reg]};
                mul_b = $signed({1'b0, rsq_i});
            end
            svdpp_pkg::MUL_U_Q: begin
                mul_a = u_reg;
                mul_b = {{(BW-FW){q_reg[lane_reg][FW-1]}}, q_reg[lane_reg]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.mul_sel != svdpp_pkg::MUL_NONE) begin
            prod_reg <= prod_next;
        end
    end

    // Round half up from Q.28 to Q.12, add the user factor
    assign prod_rnd = prod_reg + (PW'(1) <<< 15);
    assign prod_sh  = prod_rnd >>> 16;
    assign u_next   = $signed(prod_sh[AW-1:0])
                    + {{(AW-FW){user_reg[lane_reg][FW-1]}}, user_reg[lane_reg]};

    always_ff @(posedge aclk) begin
        if (ctrl_i.load_u) begin
            u_reg <= u_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl_i.acc_op)
            svdpp_pkg::ACC_CLEAR: acc_reg <= '0;
            svdpp_pkg::ACC_ADD:   acc_reg <= acc_reg + {{(CW-PW){prod_reg[PW-1]}}, prod_reg};
            default:              acc_reg <= acc_reg;
        endcase
    end

    // Round Q.24 to Q.12 and saturate
    assign acc_rnd = acc_reg + (CW'(1) <<< 11);
    assign acc_sh  = acc_rnd >>> 12;
    assign acc_hi  = acc_sh[CW-1:svdpp_pkg::RATING_W-1];
    assign sat_o   = !((&acc_hi) || !(|acc_hi));

    always_comb begin
        if (!sat_o) begin
            rating_o = $signed(acc_sh[svdpp_pkg::RATING_W-1:0]);
        end else if (acc_sh[CW-1]) begin
            rating_o = svdpp_pkg::RATING_MIN;
        end else begin
            rating_o = svdpp_pkg::RATING_MAX;
        end
    end

    assign count_o = count_reg;

endmodule

@@ hw/rtl/svdpp_rating_predictor_core.sv @@
// ----------------------------------------------------------------------------
// svdpp_rating_predictor_core
// SVD++ latent-factor rating predictor: neighbour accumulation and a
// microcoded dot-product unit with a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry requests; s_data.op selects the action.
//     op 0 adds a neighbour vector y to the running sum (dropped once
//          MAX_NEIGHBOURS vectors are in), op 1 loads the user vector p,
//     op 2 carries the movie vector q and starts a rating; op 3 is dropped.
//   m_valid/m_ready/m_data deliver one result per op 2 request:
//     rating = q . (p + R(n) * sum(y)), saturated, plus the count n used.
//   Throughput: op 0, op 1 and op 3 requests take one cycle each. An op 2
//     request holds the input through one setup step, four microcode steps
//     per factor lane on the single shared multiplier, and one result step.
//   Result: the result step loads the output register that drives m_valid.
//   Stall: a waiting result sits in the output register while new op 0/op 1
//     requests are taken; a following op 2 computes and then waits in its
//     result step until m_ready drains the register.
//   Reset (aresetn low, synchronous): sums, count and user factors clear to
//     zero, the sequencer returns to idle and m_valid drops.
// ----------------------------------------------------------------------------
module svdpp_rating_predictor_core #(
    parameter int FACTORS        = 5,
    parameter int MAX_NEIGHBOURS = 300
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  svdpp_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output svdpp_pkg::out_t   m_data
);

    svdpp_pkg::ctrl_t ctrl;
    svdpp_pkg::stat_t stat;

    logic                                   in_fire;
    logic [svdpp_pkg::RSQ_W-1:0]            rsq;
    logic                                   lane_more;
    logic [svdpp_pkg::CNT_W-1:0]            count;
    logic signed [svdpp_pkg::RATING_W-1:0]  rating;
    logic                                   sat;

    logic            out_valid_reg;
    svdpp_pkg::out_t out_reg;

    // Input side: the idle step takes every request.
    assign s_ready = ctrl.take_input;
    assign in_fire = s_valid && s_ready;

    assign stat.start     = in_fire && s_data.op == svdpp_pkg::OP_MOVIE;
    assign stat.lane_more = lane_more;
    assign stat.out_free  = !out_valid_reg || m_ready;

    svdpp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    // Table read follows the count; it is final by the time the first sum * R step uses it.
    svdpp_rsqrt_rom u_rom (
        .aclk    (aclk),
        .count_i (count),
        .rsq_o   (rsq)
    );

    svdpp_dp #(
        .FACTORS        (FACTORS),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl_i      (ctrl),
        .in_fire_i   (in_fire),
        .in_data_i   (s_data),
        .rsq_i       (rsq),
        .lane_more_o (lane_more),
        .count_o     (count),
        .rating_o    (rating),
        .sat_o       (sat)
    );

    // Output register: load on the result step, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_reg.rating          <= rating;
            out_reg.neighbours_used <= count;
            out_reg.saturated       <= sat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !ctrl.emit)
        else $error("result register overwritten while stalled");

    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.start |=> !s_ready)
        else $error("input still taken after a rating request");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> out_valid_reg && count == '0)
        else $error("neighbour state not cleared after a result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_data.op == svdpp_pkg::OP_NEIGHBOUR
            && count < svdpp_pkg::CNT_W'(MAX_NEIGHBOURS)
        |=> count == $past(count) + 9'd1)
        else $error("neighbour count did not advance");
`endif

endmodule

@@ verif/svdpp_rating_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svdpp_rating_checker
// Watches both channels of the rating predictor, keeps its own copy of the
// neighbour sums, count and user vector, predicts every rating when a movie
// request is taken and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module svdpp_rating_checker
    import svdpp_pkg::*;
#(
    parameter int FACTORS        = 5,
    parameter int MAX_NEIGHBOURS = 300
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_t         s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_t        m_data,
    output int unsigned fail_count,
    output int unsigned ratings_pending
);

    localparam int REPORT_LIMIT = 10;

    longint      y_sum [LANES];
    longint      user_vec [LANES];
    int unsigned y_count;
    out_t        expected_ratings [$];

    // Q1.16 reciprocal square root, rounded to nearest; zero count gives zero.
    function automatic logic [RSQ_W-1:0] inv_sqrt_q16(input int unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        if (n == 0) begin
            return '0;
        end
        lo = 1;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            if (odd * odd * n <= (64'd1 << 34)) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo[RSQ_W-1:0];
    endfunction

    task automatic absorb_request(input in_t d);
        longint f [LANES];
        longint scale;
        longint scaled;
        longint acc;
        longint rating;
        out_t   r;
        f[0] = $signed(d.f0);
        f[1] = $signed(d.f1);
        f[2] = $signed(d.f2);
        f[3] = $signed(d.f3);
        f[4] = $signed(d.f4);
        case (d.op)
            OP_NEIGHBOUR: begin
                if (y_count < MAX_NEIGHBOURS) begin
                    for (int i = 0; i < FACTORS; i++) begin
                        y_sum[i] += f[i];
                    end
                    y_count++;
                end
            end
            OP_USER: begin
                for (int i = 0; i < FACTORS; i++) begin
                    user_vec[i] = f[i];
                end
            end
            OP_MOVIE: begin
                scale = inv_sqrt_q16(y_count);
                acc   = 0;
                for (int i = 0; i < FACTORS; i++) begin
                    scaled = (y_sum[i] * scale + 64'sd32768) >>> 16;
                    acc += (scaled + user_vec[i]) * f[i];
                end
                rating      = (acc + 64'sd2048) >>> 12;
                r.saturated = 1'b0;
                if (rating > 64'sd2147483647) begin
                    rating      = 64'sd2147483647;
                    r.saturated = 1'b1;
                end else if (rating < -64'sd2147483648) begin
                    rating      = -64'sd2147483648;
                    r.saturated = 1'b1;
                end
                r.rating          = rating[RATING_W-1:0];
                r.neighbours_used = y_count[CNT_W-1:0];
                expected_ratings.push_back(r);
                for (int i = 0; i < LANES; i++) begin
                    y_sum[i] = 0;
                end
                y_count = 0;
            end
            default: begin
                // unused opcode: no effect
            end
        endcase
    endtask

    task automatic check_rating(input out_t got);
        out_t want;
        if (expected_ratings.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("unexpected result: rating=%0d used=%0d sat=%0b",
                         got.rating, got.neighbours_used, got.saturated);
            end
            return;
        end
        want = expected_ratings.pop_front();
        if (got.rating !== want.rating || got.neighbours_used !== want.neighbours_used
                || got.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("result mismatch: expected rating=%0d used=%0d sat=%0b,",
                         want.rating, want.neighbours_used, want.saturated);
                $display("                 got rating=%0d used=%0d sat=%0b",
                         got.rating, got.neighbours_used, got.saturated);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                y_sum[i]    = 0;
                user_vec[i] = 0;
            end
            y_count = 0;
            expected_ratings.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_request(s_data);
            end
            if (m_valid && m_ready) begin
                check_rating(m_data);
            end
        end
        ratings_pending = expected_ratings.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SVD++ rating predictor core. Drives directed
// extremes and then random rating sequences (optional user vector, neighbour
// run, usually a movie vector) with random gaps on both channels and one long
// result back-pressure window; the checker beside the core scores results.
// ----------------------------------------------------------------------------
module tb_top;
    import svdpp_pkg::*;

    localparam int FACTORS         = 5;
    localparam int MAX_NEIGHBOURS  = 300;
    localparam int RUN_ITEMS       = 2000;
    // Cycle limit for the watchdog; leave a wide margin over the slowest run.
    localparam int CYCLE_LIMIT     = 1_000_000;
    // Extra settling after the last rating is seen.
    localparam int DRAIN_CYCLES    = 4 * FACTORS + 20;
    localparam int HOLD_OFF_CYCLES = 600;

    // Opcode the core ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;

    int unsigned fail_count;
    int unsigned ratings_pending;
    int unsigned cycle_count   = 0;
    int unsigned counted_items = 0;
    logic        hold_req      = 1'b0;
    logic        rx_hold       = 1'b0;

    svdpp_rating_predictor_core #(
        .FACTORS        (FACTORS),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    svdpp_rating_checker #(
        .FACTORS        (FACTORS),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .ratings_pending (ratings_pending)
    );

    always #5 aclk = ~aclk;

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Long back-pressure window, counted here so the sender keeps offering
    // requests meanwhile: the core parks one rating in its output register,
    // computes the next one and then stalls its input.
    initial begin
        wait (hold_req);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Result sink: random stall before each result, with bursts of
    // back-to-back acceptance mixed in.
    initial begin : result_sink
        int unsigned wait_cycles;
        int unsigned burst_left;
        burst_left = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (burst_left == 0 && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(5, 30);
            end
            if (burst_left > 0) begin
                wait_cycles = 0;
                burst_left--;
            end else begin
                wait_cycles = $urandom_range(0, 19);
            end
            // Lower ready only when a stall follows, so ready never toggles
            // twice in one step.
            if (rx_hold || wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic in_t lanes_request(input logic [1:0] op,
                                          input logic signed [FACT_W-1:0] v0,
                                          input logic signed [FACT_W-1:0] v1,
                                          input logic signed [FACT_W-1:0] v2,
                                          input logic signed [FACT_W-1:0] v3,
                                          input logic signed [FACT_W-1:0] v4);
        in_t d;
        d.op = op;
        d.f0 = v0;
        d.f1 = v1;
        d.f2 = v2;
        d.f3 = v3;
        d.f4 = v4;
        return d;
    endfunction

    function automatic in_t flat_request(input logic [1:0] op,
                                         input logic signed [FACT_W-1:0] v);
        return lanes_request(op, v, v, v, v, v);
    endfunction

    // Bias toward the range ends and small values, else any 16-bit pattern.
    function automatic logic signed [FACT_W-1:0] random_factor();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return FACT_W'($urandom_range(0, 8192) - 4096);
            default: return FACT_W'($urandom());
        endcase
    endfunction

    function automatic in_t random_request(input logic [1:0] op);
        return lanes_request(op, random_factor(), random_factor(), random_factor(),
                             random_factor(), random_factor());
    endfunction

    // Offer one request and hold it until the core takes it.
    task automatic push_request(input in_t d, input bit fast);
        int unsigned gap;
        gap = fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One rating: optional user vector, neighbour run with some ignored-op
    // noise, then usually a movie request; a missing movie request leaves the
    // sums to carry into the next sequence.
    task automatic run_rating_sequence(input int unsigned neighbours, input bit fast);
        if ($urandom_range(0, 2) == 0) begin
            push_request(random_request(OP_USER), fast);
            counted_items++;
        end
        for (int unsigned n = 0; n < neighbours; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_request(random_request(OP_UNUSED), fast);
            end
            push_request(random_request(OP_NEIGHBOUR), fast);
            if (n < MAX_NEIGHBOURS) begin
                counted_items++;
            end
        end
        if ($urandom_range(0, 19) != 0) begin
            push_request(random_request(OP_MOVIE), fast);
            counted_items++;
        end
    endtask

    initial begin : stimulus
        int unsigned pick;
        int unsigned neighbours;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty neighbourhood with zero user vector.
        push_request(flat_request(OP_MOVIE, 16'sh0000), 1'b0);
        // Full-scale user and movie vectors, both signs.
        push_request(flat_request(OP_USER, 16'sh7FFF), 1'b0);
        push_request(flat_request(OP_MOVIE, 16'sh7FFF), 1'b0);
        push_request(flat_request(OP_USER, 16'sh8000), 1'b0);
        push_request(flat_request(OP_MOVIE, 16'sh8000), 1'b0);
        push_request(flat_request(OP_MOVIE, 16'sh7FFF), 1'b0);
        // Single neighbour: scale of exactly one.
        push_request(flat_request(OP_NEIGHBOUR, 16'sh7FFF), 1'b0);
        push_request(flat_request(OP_MOVIE, 16'sh7FFF), 1'b0);
        // Two most-negative neighbours.
        push_request(flat_request(OP_NEIGHBOUR, 16'sh8000), 1'b0);
        push_request(flat_request(OP_NEIGHBOUR, 16'sh8000), 1'b0);
        push_request(flat_request(OP_MOVIE, 16'sh8000), 1'b0);
        // Ignored opcode, then a rating that must see cleared sums.
        push_request(flat_request(OP_UNUSED, 16'sh7FFF), 1'b0);
        push_request(lanes_request(OP_MOVIE, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5), 1'b0);
        // Mixed bit patterns, ignored opcode inside a neighbour run.
        push_request(lanes_request(OP_USER, 16'sh5555, 16'shAAAA, 16'sh0001,
                                   16'shFFFF, 16'sh1000), 1'b0);
        push_request(lanes_request(OP_NEIGHBOUR, 16'sh1234, 16'shEDCB, 16'sh7FFF,
                                   16'sh8000, 16'sh0F0F), 1'b0);
        push_request(flat_request(OP_UNUSED, 16'sh8000), 1'b0);
        push_request(lanes_request(OP_NEIGHBOUR, 16'shAAAA, 16'sh5555, 16'shF0F0,
                                   16'sh0001, 16'shFFFF), 1'b0);
        push_request(lanes_request(OP_MOVIE, 16'shAAAA, 16'sh5555, 16'sh7FFF,
                                   16'sh8000, 16'sh0001), 1'b0);
        counted_items = 16;

        // Neighbour limit: exactly full, then overfull.
        run_rating_sequence(MAX_NEIGHBOURS, 1'b1);
        run_rating_sequence(MAX_NEIGHBOURS + 5, 1'b0);

        while (counted_items < RUN_ITEMS) begin
            // Start the long result stall midway and keep feeding requests.
            if (!hold_req && counted_items >= RUN_ITEMS / 2) begin
                hold_req <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                neighbours = $urandom_range(MAX_NEIGHBOURS - 20, MAX_NEIGHBOURS + 20);
            end else if (pick < 12) begin
                neighbours = 0;
            end else begin
                neighbours = $urandom_range(1, 12);
            end
            run_rating_sequence(neighbours, $urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        // Drain: let the checker see the last request, wait for every rating,
        // then let the pipeline settle.
        @(posedge aclk);
        while (ratings_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && ratings_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/svdpp_pkg.sv
hw/rtl/svdpp_rsqrt_rom.sv
hw/rtl/svdpp_seq.sv
hw/rtl/svdpp_dp.sv
hw/rtl/svdpp_rating_predictor_core.sv
verif/svdpp_rating_checker.sv
verif/tb_top.sv
